### hdl/i2cgx_pkg.sv
package i2cgx_pkg;

	localparam int PIN_COUNT = 24;
	localparam logic [6:0] BASE_ADDRESS = 7'h22;

	localparam logic [PIN_COUNT-1:0] PIN_MASK = {PIN_COUNT{1'b1}};

	// event codes
	localparam logic [2:0] FUNC_WRITE_START = 3'd0;
	localparam logic [2:0] FUNC_READ_START  = 3'd1;
	localparam logic [2:0] FUNC_WRITE_BYTE  = 3'd2;
	localparam logic [2:0] FUNC_READ_BYTE   = 3'd3;
	localparam logic [2:0] FUNC_STOP        = 3'd4;
	localparam logic [2:0] FUNC_PIN_SAMPLE  = 3'd5;
	localparam logic [2:0] FUNC_RESET       = 3'd6;

	// register banks, pointer bits 3..2
	localparam logic [1:0] BANK_INPUT     = 2'd0;
	localparam logic [1:0] BANK_OUTPUT    = 2'd1;
	localparam logic [1:0] BANK_POLARITY  = 2'd2;
	localparam logic [1:0] BANK_DIRECTION = 2'd3;

	// ports, pointer bits 1..0
	localparam logic [1:0] PORT_0    = 2'd0;
	localparam logic [1:0] PORT_1    = 2'd1;
	localparam logic [1:0] PORT_2    = 2'd2;
	localparam logic [1:0] PORT_NONE = 2'd3;

	localparam int CMD_AUTO_INC_BIT = 7;

	typedef struct packed {
		logic [2:0]           func;
		logic [6:0]           bus_address;
		logic [7:0]           write_data;
		logic [PIN_COUNT-1:0] pin_levels;
	} item_t;

	typedef struct packed {
		logic                 ack;
		logic [7:0]           read_data;
		logic                 irq_asserted;
		logic [PIN_COUNT-1:0] drive_enable;
		logic [PIN_COUNT-1:0] drive_level;
	} result_t;

	// 0-1-2-0 rotation; port three goes to one
	function automatic logic [1:0] rotate_port(input logic [1:0] port);
		logic [1:0] nxt;
		case (port)
			PORT_0:  nxt = PORT_1;
			PORT_1:  nxt = PORT_2;
			PORT_2:  nxt = PORT_0;
			default: nxt = PORT_1;
		endcase
		return nxt;
	endfunction

	function automatic logic [PIN_COUNT-1:0] put_byte(input logic [PIN_COUNT-1:0] value,
			input logic [1:0] port, input logic [7:0] data);
		logic [PIN_COUNT-1:0] res;
		res = value;
		case (port)
			PORT_0:  res[7:0]   = data;
			PORT_1:  res[15:8]  = data;
			PORT_2:  res[23:16] = data;
			default: res = value;
		endcase
		return res;
	endfunction

	function automatic logic [7:0] get_byte(input logic [PIN_COUNT-1:0] value,
			input logic [1:0] port);
		logic [7:0] res;
		case (port)
			PORT_0:  res = value[7:0];
			PORT_1:  res = value[15:8];
			PORT_2:  res = value[23:16];
			default: res = 8'h00;
		endcase
		return res;
	endfunction

endpackage

### hdl/i2cgx_in_stage.sv
module i2cgx_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  i2cgx_pkg::item_t in_item,
	input  logic             advance,
	output logic             valid_s1,
	output i2cgx_pkg::item_t item_s1
);
	import i2cgx_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### hdl/i2cgx_core.sv
module i2cgx_core #(
	parameter logic [6:0] BASE_ADDR = i2cgx_pkg::BASE_ADDRESS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               step,
	input  i2cgx_pkg::item_t   item,
	output i2cgx_pkg::result_t result
);
	import i2cgx_pkg::*;

	logic                 addr_select_q;
	logic [PIN_COUNT-1:0] output_q, polarity_q, direction_q, input_latch_q, last_read_q;
	logic [3:0]           reg_pointer_q;
	logic                 auto_inc_q, expect_cmd_q, irq_q;

	logic [PIN_COUNT-1:0] output_d, polarity_d, direction_d, input_latch_d, last_read_d;
	logic [3:0]           reg_pointer_d;
	logic                 auto_inc_d, expect_cmd_d, irq_d;
	logic                 match, ack;
	logic [7:0]           rdata;
	logic [1:0]           bank, port;
	logic [3:0]           advanced_ptr;
	logic [PIN_COUNT-1:0] src, enable, sampled;

	assign bank = reg_pointer_q[3:2];
	assign port = reg_pointer_q[1:0];
	assign match = item.bus_address == (BASE_ADDR + {6'd0, addr_select_q});
	assign advanced_ptr = auto_inc_q ? {bank, rotate_port(port)} : reg_pointer_q;
	assign sampled = (item.pin_levels ^ polarity_q) & direction_q;

	always_comb begin
		case (bank)
			BANK_INPUT:    src = input_latch_q;
			BANK_OUTPUT:   src = output_q;
			BANK_POLARITY: src = polarity_q;
			default:       src = direction_q;
		endcase
	end

	always_comb begin
		output_d      = output_q;
		polarity_d    = polarity_q;
		direction_d   = direction_q;
		input_latch_d = input_latch_q;
		last_read_d   = last_read_q;
		reg_pointer_d = reg_pointer_q;
		auto_inc_d    = auto_inc_q;
		expect_cmd_d  = expect_cmd_q;
		irq_d         = irq_q;
		ack           = 1'b0;
		rdata         = 8'h00;
		case (item.func)
			FUNC_WRITE_START: begin
				if (match) begin
					ack           = 1'b1;
					reg_pointer_d = 4'd0;
					auto_inc_d    = 1'b1;
					expect_cmd_d  = 1'b1;
				end
			end
			FUNC_READ_START: begin
				if (match) begin
					ack          = 1'b1;
					last_read_d  = input_latch_q;
					irq_d        = 1'b0;
					expect_cmd_d = 1'b0;
				end
			end
			FUNC_WRITE_BYTE: begin
				ack = 1'b1;
				if (expect_cmd_q) begin
					auto_inc_d    = item.write_data[CMD_AUTO_INC_BIT];
					reg_pointer_d = item.write_data[3:0];
					expect_cmd_d  = 1'b0;
				end else begin
					case (bank)
						BANK_OUTPUT:    output_d    = put_byte(output_q, port, item.write_data);
						BANK_POLARITY:  polarity_d  = put_byte(polarity_q, port, item.write_data);
						BANK_DIRECTION: direction_d = put_byte(direction_q, port, item.write_data);
						default:        output_d    = output_q;
					endcase
					reg_pointer_d = advanced_ptr;
				end
			end
			FUNC_READ_BYTE: begin
				rdata         = get_byte(src, port);
				reg_pointer_d = advanced_ptr;
			end
			FUNC_STOP: begin
				reg_pointer_d = 4'd0;
				expect_cmd_d  = 1'b0;
			end
			FUNC_PIN_SAMPLE: begin
				input_latch_d = sampled;
				irq_d         = sampled != last_read_q;
			end
			FUNC_RESET: begin
				output_d      = '0;
				polarity_d    = '0;
				direction_d   = PIN_MASK;
				input_latch_d = '0;
				last_read_d   = '0;
				reg_pointer_d = 4'd0;
				auto_inc_d    = 1'b1;
				expect_cmd_d  = 1'b0;
				irq_d         = 1'b0;
			end
			default: begin
				ack = 1'b0;
			end
		endcase
	end

	assign enable = ~direction_d;

	assign result.ack          = ack;
	assign result.read_data    = rdata;
	assign result.irq_asserted = irq_d;
	assign result.drive_enable = enable;
	assign result.drive_level  = output_d & enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_select_q <= 1'b0;
		end else if (cfg_we) begin
			addr_select_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_q      <= '0;
			polarity_q    <= '0;
			direction_q   <= PIN_MASK;
			input_latch_q <= '0;
			last_read_q   <= '0;
			reg_pointer_q <= 4'd0;
			auto_inc_q    <= 1'b1;
			expect_cmd_q  <= 1'b0;
			irq_q         <= 1'b0;
		end else if (step) begin
			output_q      <= output_d;
			polarity_q    <= polarity_d;
			direction_q   <= direction_d;
			input_latch_q <= input_latch_d;
			last_read_q   <= last_read_d;
			reg_pointer_q <= reg_pointer_d;
			auto_inc_q    <= auto_inc_d;
			expect_cmd_q  <= expect_cmd_d;
			irq_q         <= irq_d;
		end
	end

endmodule

### hdl/i2cgx_out_stage.sv
module i2cgx_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  i2cgx_pkg::result_t result,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output i2cgx_pkg::result_t result_s2
);
	import i2cgx_pkg::*;

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			result_s2 <= result;
		end
	end

endmodule

### hdl/i2c_gpio_expander_24bit_top.sv
// 24-pin I2C port expander at address 0x22 plus the addr_select strap. Each
// item is one bus event (tuser selects it) and yields exactly one result item.
// The input register feeds the register banks and a result register; an item
// moves from the input register to the result register, and one item is taken
// every cycle, limited only by tready on the result side. cfg_we writes the
// strap and must only be used while no item is in flight.
module i2c_gpio_expander_24bit_top #(
	parameter logic [6:0] BASE_ADDR = i2cgx_pkg::BASE_ADDRESS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,    // addr_select
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,      // bus_address, write_data, pin_levels, zero pad
	input  logic [2:0]  s_tuser,      // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata       // ack, read_data, irq_asserted, drive_enable,
	                                  // drive_level, zero pad
);
	import i2cgx_pkg::*;

	item_t   in_item, item_s1;
	result_t result, result_s2;
	logic    valid_s1, can_load, step;

	assign in_item.func        = s_tuser;
	assign in_item.bus_address = s_tdata[6:0];
	assign in_item.write_data  = s_tdata[14:7];
	assign in_item.pin_levels  = s_tdata[38:15];

	assign step = valid_s1 && can_load;

	i2cgx_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cgx_core #(
		.BASE_ADDR (BASE_ADDR)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item      (item_s1),
		.result    (result)
	);

	i2cgx_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result    (result),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_s2 (result_s2)
	);

	assign m_tdata = {6'd0, result_s2.drive_level, result_s2.drive_enable,
		result_s2.irq_asserted, result_s2.read_data, result_s2.ack};

endmodule
